/* hdl/rlbd_pkg.sv */
package rlbd_pkg;

    localparam int SAMPLE_W = 12;
    localparam int TIME_W = 32;
    localparam int SETTLE_W = 16;
    localparam int BUTTON_W = 3;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 16;
    localparam int QUEUE_DEPTH = 2;

    typedef enum logic [BUTTON_W-1:0] {
        BTN_NONE    = 3'd0,
        BTN_UP      = 3'd1,
        BTN_DOWN    = 3'd2,
        BTN_PRESET1 = 3'd3,
        BTN_PRESET2 = 3'd4
    } t_button;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_UP_MAX          = 3'd0,
        REG_DOWN_LOW        = 3'd1,
        REG_DOWN_HIGH       = 3'd2,
        REG_PRESET_ONE_LOW  = 3'd3,
        REG_PRESET_ONE_HIGH = 3'd4,
        REG_PRESET_TWO_LOW  = 3'd5,
        REG_PRESET_TWO_HIGH = 3'd6,
        REG_SETTLE_MS       = 3'd7
    } t_cfg_reg;

    localparam logic [SAMPLE_W-1:0] RST_UP_MAX          = 12'd300;
    localparam logic [SAMPLE_W-1:0] RST_DOWN_LOW        = 12'd600;
    localparam logic [SAMPLE_W-1:0] RST_DOWN_HIGH       = 12'd1000;
    localparam logic [SAMPLE_W-1:0] RST_PRESET_ONE_LOW  = 12'd1300;
    localparam logic [SAMPLE_W-1:0] RST_PRESET_ONE_HIGH = 12'd1800;
    localparam logic [SAMPLE_W-1:0] RST_PRESET_TWO_LOW  = 12'd2100;
    localparam logic [SAMPLE_W-1:0] RST_PRESET_TWO_HIGH = 12'd2600;
    localparam logic [SETTLE_W-1:0] RST_SETTLE_MS       = 16'd50;

    typedef struct packed {
        t_button           code;
        logic [TIME_W-1:0] now_ms;
    } t_poll;

endpackage

/* hdl/rlbd_if.sv */
interface rlbd_poll_if
    import rlbd_pkg::*;
    ();
    logic                valid;
    logic                ready;
    logic [SAMPLE_W-1:0] adc_sample;
    logic [TIME_W-1:0]   now_ms;

    modport source (output valid, adc_sample, now_ms, input ready);
    modport sink (input valid, adc_sample, now_ms, output ready);
endinterface

interface rlbd_result_if
    import rlbd_pkg::*;
    ();
    logic                valid;
    logic                ready;
    logic [BUTTON_W-1:0] stable_button;
    logic [BUTTON_W-1:0] press_edge;

    modport source (output valid, stable_button, press_edge, input ready);
    modport sink (input valid, stable_button, press_edge, output ready);
endinterface

interface rlbd_cfg_if
    import rlbd_pkg::*;
    ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

/* hdl/rlbd_front.sv */
module rlbd_front
    import rlbd_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    rlbd_poll_if.sink           i_poll,
    rlbd_cfg_if.sink            i_cfg,
    input  logic                i_q_ready,
    output logic                o_q_push,
    output t_poll               o_q_data,
    output logic [SETTLE_W-1:0] o_settle_ms
);

    logic [SAMPLE_W-1:0] r_up_max;
    logic [SAMPLE_W-1:0] r_down_low;
    logic [SAMPLE_W-1:0] r_down_high;
    logic [SAMPLE_W-1:0] r_p1_low;
    logic [SAMPLE_W-1:0] r_p1_high;
    logic [SAMPLE_W-1:0] r_p2_low;
    logic [SAMPLE_W-1:0] r_p2_high;
    logic [SETTLE_W-1:0] r_settle;
    logic [SAMPLE_W-1:0] cfg_v12;
    t_button             code;

    assign cfg_v12 = i_cfg.data[SAMPLE_W-1:0];
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_up_max   <= RST_UP_MAX;
            r_down_low <= RST_DOWN_LOW;
            r_down_high <= RST_DOWN_HIGH;
            r_p1_low   <= RST_PRESET_ONE_LOW;
            r_p1_high  <= RST_PRESET_ONE_HIGH;
            r_p2_low   <= RST_PRESET_TWO_LOW;
            r_p2_high  <= RST_PRESET_TWO_HIGH;
            r_settle   <= RST_SETTLE_MS;
        end else if (i_cfg.valid) begin
            unique case (t_cfg_reg'(i_cfg.index))
                REG_UP_MAX:          r_up_max <= cfg_v12;
                REG_DOWN_LOW:        r_down_low <= cfg_v12;
                REG_DOWN_HIGH:       r_down_high <= cfg_v12;
                REG_PRESET_ONE_LOW:  r_p1_low <= cfg_v12;
                REG_PRESET_ONE_HIGH: r_p1_high <= cfg_v12;
                REG_PRESET_TWO_LOW:  r_p2_low <= cfg_v12;
                REG_PRESET_TWO_HIGH: r_p2_high <= cfg_v12;
                REG_SETTLE_MS:       r_settle <= i_cfg.data[SETTLE_W-1:0];
                default:             r_settle <= r_settle;
            endcase
        end
    end

    // priority decode of the ladder voltage
    always_comb begin
        priority if (i_poll.adc_sample < r_up_max) begin
            code = BTN_UP;
        end else if (i_poll.adc_sample >= r_down_low && i_poll.adc_sample <= r_down_high) begin
            code = BTN_DOWN;
        end else if (i_poll.adc_sample >= r_p1_low && i_poll.adc_sample <= r_p1_high) begin
            code = BTN_PRESET1;
        end else if (i_poll.adc_sample >= r_p2_low && i_poll.adc_sample <= r_p2_high) begin
            code = BTN_PRESET2;
        end else begin
            code = BTN_NONE;
        end
    end

    assign i_poll.ready = i_q_ready;
    assign o_q_push = i_poll.valid && i_q_ready;
    assign o_q_data = '{code: code, now_ms: i_poll.now_ms};
    assign o_settle_ms = r_settle;

endmodule

/* hdl/rlbd_queue.sv */
module rlbd_queue
    import rlbd_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_poll i_data,
    output logic  o_ready,
    input  logic  i_pop,
    output logic  o_valid,
    output t_poll o_data
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL = CW'(DEPTH);

    t_poll         mem [DEPTH];
    logic [AW-1:0] r_wr_ptr;
    logic [AW-1:0] r_rd_ptr;
    logic [CW-1:0] r_count;
    logic [CW-1:0] n_count;

    assign o_ready = r_count != FULL;
    assign o_valid = r_count != '0;
    assign o_data = mem[r_rd_ptr];

    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + CW'(1);
        end else if (i_pop && !i_push) begin
            n_count = r_count - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count <= '0;
        end else begin
            r_count <= n_count;
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == LAST) ? '0 : r_wr_ptr + AW'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == LAST) ? '0 : r_rd_ptr + AW'(1);
            end
        end
    end

endmodule

/* hdl/rlbd_back.sv */
module rlbd_back
    import rlbd_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_q_valid,
    input  t_poll               i_q_data,
    output logic                o_q_pop,
    input  logic [SETTLE_W-1:0] i_settle_ms,
    rlbd_result_if.source       o_result
);

    t_button           r_cand;
    logic [TIME_W-1:0] r_since;
    t_button           r_settled;
    logic              r_out_valid;
    t_button           r_out_stable;
    t_button           r_out_edge;

    logic [TIME_W-1:0] n_since;
    logic [TIME_W-1:0] elapsed;
    t_button           n_settled;
    t_button           n_edge;

    assign o_q_pop = i_q_valid && (!r_out_valid || o_result.ready);

    always_comb begin
        n_since = (i_q_data.code != r_cand) ? i_q_data.now_ms : r_since;
        elapsed = i_q_data.now_ms - n_since;
        n_settled = (elapsed >= TIME_W'(i_settle_ms)) ? i_q_data.code : r_settled;
        n_edge = (n_settled != BTN_NONE && n_settled != r_settled) ? n_settled : BTN_NONE;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cand <= BTN_NONE;
            r_since <= '0;
            r_settled <= BTN_NONE;
            r_out_valid <= 1'b0;
        end else begin
            if (o_q_pop) begin
                r_cand <= i_q_data.code;
                r_since <= n_since;
                r_settled <= n_settled;
                r_out_valid <= 1'b1;
            end else if (o_result.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_out_stable <= n_settled;
            r_out_edge <= n_edge;
        end
    end

    assign o_result.valid = r_out_valid;
    assign o_result.stable_button = r_out_stable;
    assign o_result.press_edge = r_out_edge;

endmodule

/* hdl/resistor_ladder_button_debouncer.sv */
// channel   dir  handshake     payload
// i_poll    in   valid/ready   adc_sample[11:0], now_ms[31:0]
// i_cfg     in   valid/ready   index[2:0], data[15:0]
// o_result  out  valid/ready   stable_button[2:0], press_edge[2:0]
//
// one poll per cycle while the queue has room; a poll is decoded into the queue
// when it is accepted, and its debounce update is registered into the output
// register when the back end pops it, which waits while a result is unaccepted
// the queue holds QUEUE_DEPTH polls and the output register one more; input
// ready drops once the queue is full; i_cfg is always ready
// synchronous active-low reset restores the default thresholds and clears
// the candidate and stable button
module resistor_ladder_button_debouncer
    import rlbd_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    rlbd_poll_if.sink     i_poll,
    rlbd_cfg_if.sink      i_cfg,
    rlbd_result_if.source o_result
);

    logic                q_ready;
    logic                q_push;
    t_poll               q_wdata;
    logic                q_valid;
    logic                q_pop;
    t_poll               q_rdata;
    logic [SETTLE_W-1:0] settle_ms;

    rlbd_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_poll     (i_poll),
        .i_cfg      (i_cfg),
        .i_q_ready  (q_ready),
        .o_q_push   (q_push),
        .o_q_data   (q_wdata),
        .o_settle_ms(settle_ms)
    );

    rlbd_queue #(
        .DEPTH(DEPTH)
    ) u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (q_push),
        .i_data (q_wdata),
        .o_ready(q_ready),
        .i_pop  (q_pop),
        .o_valid(q_valid),
        .o_data (q_rdata)
    );

    rlbd_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_valid  (q_valid),
        .i_q_data   (q_rdata),
        .o_q_pop    (q_pop),
        .i_settle_ms(settle_ms),
        .o_result   (o_result)
    );

endmodule

/* test/tb_top.sv */
module tb_top;
    import rlbd_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 400000;
    localparam int HOLD_AT     = 700;
    localparam int HOLD_LEN    = 160;
    localparam int MAX_PRINTS  = 30;

    typedef struct {
        logic [SAMPLE_W-1:0] sample;
        logic [TIME_W-1:0]   stamp;
    } t_stim;

    typedef struct {
        t_button stable;
        t_button press;
    } t_buttons;

    logic i_clk;
    logic i_rst_n;

    rlbd_poll_if   poll ();
    rlbd_cfg_if    cfg ();
    rlbd_result_if res ();

    resistor_ladder_button_debouncer u_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_poll   (poll),
        .i_cfg    (cfg),
        .o_result (res)
    );

    // items still to be offered and results still owed
    t_stim    polls_waiting[$];
    t_buttons buttons_due[$];

    // thresholds as the block holds them, and as the stimulus plans them
    logic [CFG_DATA_W-1:0] limit_reg [8];
    logic [CFG_DATA_W-1:0] plan [8];

    t_button           cand_button;
    logic [TIME_W-1:0] cand_since;
    t_button           settled_button;

    logic [TIME_W-1:0] clock_ms;
    t_stim             next_poll;
    t_buttons          want;
    int                gap_left;
    int                stall_left;
    int                hold_left;
    bit                hold_done;
    bit                gaps_off;
    int                polls_sent;
    int                results_seen;
    int                edges_seen;
    int                errors;
    int                settings;
    int                cycles;

    task automatic report(string msg);
        if (errors < MAX_PRINTS) begin
            $display("tb_top: mismatch at %0t: %s", $time, msg);
        end
        errors++;
    endtask

    function automatic t_button decode_level(logic [SAMPLE_W-1:0] s);
        if (s < limit_reg[REG_UP_MAX][SAMPLE_W-1:0]) return BTN_UP;
        if (s >= limit_reg[REG_DOWN_LOW][SAMPLE_W-1:0]
                && s <= limit_reg[REG_DOWN_HIGH][SAMPLE_W-1:0]) return BTN_DOWN;
        if (s >= limit_reg[REG_PRESET_ONE_LOW][SAMPLE_W-1:0]
                && s <= limit_reg[REG_PRESET_ONE_HIGH][SAMPLE_W-1:0]) return BTN_PRESET1;
        if (s >= limit_reg[REG_PRESET_TWO_LOW][SAMPLE_W-1:0]
                && s <= limit_reg[REG_PRESET_TWO_HIGH][SAMPLE_W-1:0]) return BTN_PRESET2;
        return BTN_NONE;
    endfunction

    function automatic void debounce_poll(logic [SAMPLE_W-1:0] s, logic [TIME_W-1:0] now);
        t_button           code;
        t_button           prev;
        logic [TIME_W-1:0] elapsed;
        t_buttons          b;
        code = decode_level(s);
        if (code != cand_button) begin
            cand_button = code;
            cand_since  = now;
        end
        prev    = settled_button;
        elapsed = now - cand_since;
        if (elapsed >= {16'h0, limit_reg[REG_SETTLE_MS]}) settled_button = cand_button;
        b.stable = settled_button;
        b.press  = (settled_button != BTN_NONE && settled_button != prev)
                   ? settled_button : BTN_NONE;
        buttons_due.push_back(b);
    endfunction

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // poll driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            poll.valid     <= 1'b0;
            polls_sent     <= 0;
            gap_left       = 0;
            cand_button    = BTN_NONE;
            cand_since     = '0;
            settled_button = BTN_NONE;
        end else begin
            if (poll.valid && poll.ready) begin
                debounce_poll(poll.adc_sample, poll.now_ms);
                polls_sent <= polls_sent + 1;
                gap_left   = gaps_off ? 0 : $urandom_range(0, 13);
            end
            if (!(poll.valid && !poll.ready)) begin
                if (gap_left > 0) begin
                    poll.valid <= 1'b0;
                    gap_left--;
                end else if (polls_waiting.size() > 0) begin
                    next_poll       = polls_waiting.pop_front();
                    poll.valid      <= 1'b1;
                    poll.adc_sample <= next_poll.sample;
                    poll.now_ms     <= next_poll.stamp;
                end else begin
                    poll.valid <= 1'b0;
                end
            end
        end
    end

    // register shadow
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            limit_reg[REG_UP_MAX]          <= 16'(RST_UP_MAX);
            limit_reg[REG_DOWN_LOW]        <= 16'(RST_DOWN_LOW);
            limit_reg[REG_DOWN_HIGH]       <= 16'(RST_DOWN_HIGH);
            limit_reg[REG_PRESET_ONE_LOW]  <= 16'(RST_PRESET_ONE_LOW);
            limit_reg[REG_PRESET_ONE_HIGH] <= 16'(RST_PRESET_ONE_HIGH);
            limit_reg[REG_PRESET_TWO_LOW]  <= 16'(RST_PRESET_TWO_LOW);
            limit_reg[REG_PRESET_TWO_HIGH] <= 16'(RST_PRESET_TWO_HIGH);
            limit_reg[REG_SETTLE_MS]       <= RST_SETTLE_MS;
        end else if (cfg.valid && cfg.ready) begin
            if (cfg.index == REG_SETTLE_MS) begin
                limit_reg[cfg.index] <= cfg.data;
            end else begin
                limit_reg[cfg.index] <= {4'h0, cfg.data[SAMPLE_W-1:0]};
            end
        end
    end

    // long output stall once traffic is under way
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_left <= 0;
            hold_done <= 1'b0;
        end else if (!hold_done && polls_sent >= HOLD_AT) begin
            hold_left <= HOLD_LEN;
            hold_done <= 1'b1;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // result monitor
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            res.ready    <= 1'b0;
            results_seen <= 0;
            stall_left   = 0;
        end else begin
            if (res.valid && res.ready) begin
                results_seen <= results_seen + 1;
                if (buttons_due.size() == 0) begin
                    report("result with no poll waiting");
                end else begin
                    want = buttons_due.pop_front();
                    if (res.stable_button !== want.stable) begin
                        report($sformatf("stable_button %0d, want %0d",
                                         res.stable_button, want.stable));
                    end
                    if (res.press_edge !== want.press) begin
                        report($sformatf("press_edge %0d, want %0d",
                                         res.press_edge, want.press));
                    end
                    if (want.press != BTN_NONE) edges_seen++;
                end
                stall_left = gaps_off ? 0 : $urandom_range(0, 13);
            end
            if (hold_left > 0 || stall_left > 0) begin
                res.ready <= 1'b0;
                if (stall_left > 0) stall_left--;
            end else begin
                res.ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("tb_top: errors");
            $finish;
        end
    end

    task automatic write_reg(t_cfg_reg idx, logic [CFG_DATA_W-1:0] d);
        @(posedge i_clk);
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data  <= d;
        do @(posedge i_clk); while (!cfg.ready);
        cfg.valid <= 1'b0;
    endtask

    // upper nibble of the narrow registers is don't-care
    task automatic apply_plan();
        for (int r = 0; r < 8; r++) begin
            if (t_cfg_reg'(r) == REG_SETTLE_MS) begin
                write_reg(t_cfg_reg'(r), plan[r]);
            end else begin
                write_reg(t_cfg_reg'(r), {4'($urandom), plan[r][SAMPLE_W-1:0]});
            end
        end
        settings++;
    endtask

    task automatic draw_plan();
        int v[$];
        if ($urandom_range(0, 1)) begin
            for (int i = 0; i < 7; i++) v.push_back($urandom_range(0, 4095));
            v.sort();
            for (int i = 0; i < 7; i++) plan[i] = 16'(v[i]);
        end else begin
            for (int i = 0; i < 7; i++) plan[i] = 16'($urandom_range(0, 4095));
        end
        case ($urandom_range(0, 4))
            0: plan[REG_SETTLE_MS] = '0;
            1: plan[REG_SETTLE_MS] = 16'($urandom_range(1, 20));
            2: plan[REG_SETTLE_MS] = 16'd50;
            3: plan[REG_SETTLE_MS] = 16'($urandom);
            default: plan[REG_SETTLE_MS] = 16'hFFFF;
        endcase
    endtask

    function automatic logic [SAMPLE_W-1:0] pick_sample(t_button b);
        logic [SAMPLE_W-1:0] lo;
        logic [SAMPLE_W-1:0] hi;
        case (b)
            BTN_UP: begin
                if (plan[REG_UP_MAX][SAMPLE_W-1:0] == 0) return 12'($urandom);
                return 12'($urandom_range(0, plan[REG_UP_MAX][SAMPLE_W-1:0] - 1));
            end
            BTN_DOWN: begin
                lo = plan[REG_DOWN_LOW][SAMPLE_W-1:0];
                hi = plan[REG_DOWN_HIGH][SAMPLE_W-1:0];
            end
            BTN_PRESET1: begin
                lo = plan[REG_PRESET_ONE_LOW][SAMPLE_W-1:0];
                hi = plan[REG_PRESET_ONE_HIGH][SAMPLE_W-1:0];
            end
            BTN_PRESET2: begin
                lo = plan[REG_PRESET_TWO_LOW][SAMPLE_W-1:0];
                hi = plan[REG_PRESET_TWO_HIGH][SAMPLE_W-1:0];
            end
            default: return 12'($urandom);
        endcase
        if (lo > hi) return 12'($urandom);
        return 12'($urandom_range(lo, hi));
    endfunction

    // presses held for a while with bounce, time jumps and wraps mixed in
    task automatic add_presses(int n);
        t_button             target;
        int                  run;
        logic [SAMPLE_W-1:0] s;
        while (n > 0) begin
            target = t_button'($urandom_range(0, 4));
            run    = $urandom_range(1, 12);
            for (int k = 0; k < run && n > 0; k++) begin
                s = ($urandom_range(0, 9) < 8) ? pick_sample(target) : 12'($urandom);
                if ($urandom_range(0, 19) == 0) begin
                    clock_ms = $urandom;
                end else begin
                    clock_ms += $urandom_range(0, plan[REG_SETTLE_MS] / 3 + 3);
                end
                polls_waiting.push_back('{s, clock_ms});
                n--;
            end
        end
    endtask

    task automatic add_poll(logic [SAMPLE_W-1:0] s, logic [TIME_W-1:0] t);
        polls_waiting.push_back('{s, t});
    endtask

    // sampled away from the rising edge so the driver has settled
    task automatic wait_idle();
        do @(negedge i_clk);
        while (polls_waiting.size() != 0 || poll.valid || results_seen != polls_sent);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic run_phase(int n, bit quiet);
        gaps_off <= quiet;
        apply_plan();
        clock_ms = $urandom;
        add_presses(n);
        wait_idle();
    endtask

    initial begin
        i_rst_n         = 1'b0;
        poll.valid      = 1'b0;
        poll.adc_sample = '0;
        poll.now_ms     = '0;
        cfg.valid       = 1'b0;
        cfg.index       = REG_UP_MAX;
        cfg.data        = '0;
        res.ready       = 1'b0;
        gaps_off        = 1'b0;
        errors          = 0;
        edges_seen      = 0;
        settings        = 1;
        cycles          = 0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // window edges under the reset thresholds
        add_poll(12'd0,    32'd0);
        add_poll(12'd299,  32'd49);
        add_poll(12'd299,  32'd50);
        add_poll(12'd300,  32'd60);
        add_poll(12'd599,  32'd110);
        add_poll(12'd600,  32'd120);
        add_poll(12'd1000, 32'd170);
        add_poll(12'd1001, 32'd171);
        add_poll(12'd1299, 32'd172);
        add_poll(12'd1300, 32'd180);
        add_poll(12'd1800, 32'd230);
        add_poll(12'd1801, 32'd240);
        add_poll(12'd2099, 32'd245);
        add_poll(12'd2100, 32'd250);
        add_poll(12'd2600, 32'd300);
        add_poll(12'd2601, 32'd310);
        add_poll(12'd4095, 32'd360);
        // timestamp wrapping past zero
        add_poll(12'd0,    32'hFFFF_FFF0);
        add_poll(12'd0,    32'h0000_0022);
        // timestamp running backwards
        add_poll(12'd1500, 32'h0000_1000);
        add_poll(12'd1500, 32'h0000_0FFF);
        add_poll(12'd4095, 32'hFFFF_FFFF);
        add_poll(12'd3000, 32'h8000_0000);
        add_poll(12'd2048, 32'h7FFF_FFFF);
        wait_idle();

        // all thresholds at the top, longest settle time
        foreach (plan[i]) plan[i] = 16'hFFFF;
        run_phase(30, 1'b0);

        // all thresholds at zero, zero settle time
        foreach (plan[i]) plan[i] = '0;
        run_phase(30, 1'b1);

        // overlapping windows and an inverted one
        plan[REG_UP_MAX]          = 16'd200;
        plan[REG_DOWN_LOW]        = 16'd500;
        plan[REG_DOWN_HIGH]       = 16'd3000;
        plan[REG_PRESET_ONE_LOW]  = 16'd1000;
        plan[REG_PRESET_ONE_HIGH] = 16'd2000;
        plan[REG_PRESET_TWO_LOW]  = 16'd3000;
        plan[REG_PRESET_TWO_HIGH] = 16'd100;
        plan[REG_SETTLE_MS]       = '0;
        run_phase(40, 1'b0);

        for (int p = 0; p < 6; p++) begin
            draw_plan();
            run_phase(215, p % 3 == 1);
        end

        if (buttons_due.size() != 0) begin
            report($sformatf("%0d results never arrived", buttons_due.size()));
        end
        $display("%0d polls checked under %0d threshold settings, %0d press edges seen",
                 polls_sent, settings, edges_seen);
        $display("included wrapping and backward timestamps and one long output stall");
        if (errors == 0) begin
            $display("tb_top: clean");
        end else begin
            $display("tb_top: errors");
        end
        $finish;
    end

endmodule

/* sim.f */
hdl/rlbd_pkg.sv
hdl/rlbd_if.sv
hdl/rlbd_front.sv
hdl/rlbd_queue.sv
hdl/rlbd_back.sv
hdl/resistor_ladder_button_debouncer.sv
test/tb_top.sv
